FILE: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FLA_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fla assertion failed");

// next-cycle implication, disabled in reset
`define FLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fla assertion failed");

`endif

FILE: design/fla_pkg.sv
// shared types and constants of the free list heap allocator
// no dependencies
package fla_pkg;

  localparam int FREE_SLOTS  = 64;
  localparam int GRANT_SLOTS = 64;
  localparam int ADDR_BITS   = 16;

  localparam int SIZE_W     = 16;
  localparam int REQ_W      = 16;
  localparam int NEED_W     = 17;
  localparam int ALIGN_W    = 13;
  localparam int HDR_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int SEARCH_W   = 7;
  localparam int FIDX_W     = $clog2(FREE_SLOTS);
  localparam int FCNT_W     = $clog2(FREE_SLOTS + 1);
  localparam int GIDX_W     = $clog2(GRANT_SLOTS);
  localparam int GCNT_W     = $clog2(GRANT_SLOTS + 1);
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FIT    = 2'd1,
    STATUS_NOT_ALLOC = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  // fit policy codes
  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;

  // return order codes
  localparam logic [2:0] ORDER_BACK    = 3'd0;
  localparam logic [2:0] ORDER_FRONT   = 3'd1;
  localparam logic [2:0] ORDER_ADDR    = 3'd2;
  localparam logic [2:0] ORDER_SIZE_UP = 3'd3;
  localparam logic [2:0] ORDER_SIZE_DN = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RETURN_ORDER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COALESCE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGNMENT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_LENGTH  = 3'd6;

  // reset values of the configuration
  localparam logic [1:0]           RST_FIT_POLICY   = FIT_BEST;
  localparam logic [2:0]           RST_RETURN_ORDER = ORDER_ADDR;
  localparam logic [ADDR_BITS-1:0] RST_HEAP_BASE    = 16'd1000;
  localparam logic [SIZE_W-1:0]    RST_HEAP_LENGTH  = 16'd100;

  // one free chunk or one grant record
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
  } chunk_t;

endpackage

FILE: design/fla_if.sv
// request and response channels of the free list heap allocator
// depends on fla_pkg
interface fla_req_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [fla_pkg::REQ_W-1:0]         request_size;
  logic [fla_pkg::ADDR_BITS-1:0]     release_addr;

  modport source (output valid, output op, output request_size, output release_addr,
                  input ready);
  modport sink (input valid, input op, input request_size, input release_addr,
                output ready);
endinterface

interface fla_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fla_pkg::STATUS_W-1:0]      status;
  logic [fla_pkg::ADDR_BITS-1:0]     grant_addr;
  logic [fla_pkg::SEARCH_W-1:0]      searched;

  modport source (output valid, output status, output grant_addr, output searched,
                  input ready);
  modport sink (input valid, input status, input grant_addr, input searched,
                output ready);
endinterface

FILE: design/free_list_heap_allocator.sv
// Free list heap allocator: one request at a time through a small sequencer over two RAMs.
// An alloc finds the alignment padding when alignment is set, searches the free list, scans the
// grant slots, and on an exact fit moves the later entries down. A free scans the grant slots,
// then inserts at the back, at the front by a shift, or by an insertion sort, and may coalesce.
// A new request is taken only after the last result has gone to the output register.
// Synchronous reset restores the configuration, one free chunk (base, length), no grants.
module free_list_heap_allocator (
  input  logic                                clk,
  input  logic                                rst,
  fla_req_if.sink                             req,
  fla_rsp_if.source                           rsp,
  input  logic                                cfg_write,
  input  logic [fla_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_ALIGN, S_NEED, S_FRD, S_FCMP, S_FEND, S_GRD, S_GCMP, S_GEND,
    S_RM_RD, S_RM_WR, S_ALLOC_FIN, S_SH_RD, S_SH_WR, S_SORT_K, S_SORT_KW,
    S_SORT_P, S_SORT_PC, S_MRG_START, S_MRG_FIRST, S_MRG_RD, S_MRG_CMP,
    S_FREE_FIN, S_RESP
  } state_t;

  localparam int BITCNT_W = $clog2(fla_pkg::REQ_W + 1);
  localparam int GRANT_VALID_W = fla_pkg::GRANT_SLOTS;

  state_t state;

  // configuration
  logic [1:0]                       fit_policy;
  logic [2:0]                       return_order;
  logic                             coalesce_enable;
  logic [fla_pkg::ALIGN_W-1:0]      alignment;
  logic [fla_pkg::HDR_W-1:0]        header_bytes;
  logic [fla_pkg::ADDR_BITS-1:0]    heap_base;
  logic [fla_pkg::SIZE_W-1:0]       heap_length;

  // request and working registers
  logic                             op_r;
  logic [fla_pkg::REQ_W-1:0]        req_size;
  logic [fla_pkg::REQ_W-1:0]        req_sh;
  logic [BITCNT_W-1:0]              bit_ctr;
  logic [fla_pkg::ALIGN_W-1:0]      rem;
  logic [fla_pkg::NEED_W-1:0]       need;
  logic [fla_pkg::ADDR_BITS-1:0]    look_addr;
  logic [fla_pkg::FCNT_W-1:0]       count;
  logic [fla_pkg::FCNT_W-1:0]       fi;
  logic [fla_pkg::FCNT_W-1:0]       cnt;
  logic                             found;
  logic [fla_pkg::FIDX_W-1:0]       best_idx;
  logic [fla_pkg::SIZE_W-1:0]       best_size;
  logic [fla_pkg::ADDR_BITS-1:0]    best_addr;
  logic [fla_pkg::GCNT_W-1:0]       gi;
  logic                             match_found;
  logic [fla_pkg::GIDX_W-1:0]       match_slot;
  logic                             free_found;
  logic [fla_pkg::GIDX_W-1:0]       free_slot;
  logic [fla_pkg::SIZE_W-1:0]       g_size;
  logic [fla_pkg::GIDX_W-1:0]       grant_slot;
  logic [GRANT_VALID_W-1:0]         gvalid;
  logic [fla_pkg::FCNT_W-1:0]       ii;
  logic [fla_pkg::FCNT_W-1:0]       j;
  logic [fla_pkg::FCNT_W-1:0]       n;
  fla_pkg::chunk_t                  key;
  fla_pkg::chunk_t                  cur;

  // result and output registers
  fla_pkg::status_t                 res_status;
  logic [fla_pkg::ADDR_BITS-1:0]    res_addr;
  logic [fla_pkg::SEARCH_W-1:0]     res_searched;
  logic                             out_valid;
  fla_pkg::status_t                 out_status;
  logic [fla_pkg::ADDR_BITS-1:0]    out_addr;
  logic [fla_pkg::SEARCH_W-1:0]     out_searched;

  // free list and grant memories
  fla_pkg::chunk_t                  fmem [fla_pkg::FREE_SLOTS];
  fla_pkg::chunk_t                  gmem [fla_pkg::GRANT_SLOTS];
  logic                             f_we;
  logic [fla_pkg::FIDX_W-1:0]       f_wa;
  logic [fla_pkg::FIDX_W-1:0]       f_ra;
  fla_pkg::chunk_t                  f_wd;
  fla_pkg::chunk_t                  f_rd;
  logic                             g_we;
  logic [fla_pkg::GIDX_W-1:0]       g_wa;
  logic [fla_pkg::GIDX_W-1:0]       g_ra;
  fla_pkg::chunk_t                  g_wd;
  fla_pkg::chunk_t                  g_rd;

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_wa] <= f_wd;
    end
    f_rd <= fmem[f_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_wa] <= g_wd;
    end
    g_rd <= gmem[g_ra];
  end

  // heap restart on a base or length write
  logic                             restart;
  logic [fla_pkg::ADDR_BITS-1:0]    new_base;
  logic [fla_pkg::SIZE_W-1:0]       new_len;

  assign restart  = cfg_write && (cfg_index == fla_pkg::REG_HEAP_BASE ||
                                  cfg_index == fla_pkg::REG_HEAP_LENGTH);
  assign new_base = (cfg_index == fla_pkg::REG_HEAP_BASE) ?
                    cfg_data[fla_pkg::ADDR_BITS-1:0] : heap_base;
  assign new_len  = (cfg_index == fla_pkg::REG_HEAP_LENGTH) ?
                    cfg_data[fla_pkg::SIZE_W-1:0] : heap_length;

  // alignment remainder step (restoring, one bit a cycle)
  logic [fla_pkg::ALIGN_W:0]        div_try;
  logic [fla_pkg::ALIGN_W:0]        div_diff;
  logic [fla_pkg::NEED_W-1:0]       pad;
  logic [fla_pkg::NEED_W-1:0]       need_calc;

  assign div_try   = {rem, req_sh[fla_pkg::REQ_W-1]};
  assign div_diff  = div_try - {1'b0, alignment};
  assign pad       = (rem != '0) ? (fla_pkg::NEED_W'(alignment) - fla_pkg::NEED_W'(rem)) : '0;
  assign need_calc = fla_pkg::NEED_W'(req_size) + pad + fla_pkg::NEED_W'(header_bytes);

  // fit compare on the entry just read
  logic                             fit_hit;
  logic                             fit_first;

  assign fit_first = (fit_policy >= fla_pkg::FIT_FIRST);
  assign fit_hit   = (fla_pkg::NEED_W'(f_rd.size) >= need) &&
                     (!found || fit_first ||
                      (fit_policy == fla_pkg::FIT_BEST  && f_rd.size < best_size) ||
                      (fit_policy == fla_pkg::FIT_WORST && f_rd.size > best_size));

  // grant slot choice and split test
  logic                             slot_ok;
  logic [fla_pkg::GIDX_W-1:0]       slot_sel;
  logic                             split;
  logic [fla_pkg::SIZE_W-1:0]       need16;
  logic                             g_hit;

  assign slot_ok  = match_found || free_found;
  assign slot_sel = match_found ? match_slot : free_slot;
  assign split    = fla_pkg::NEED_W'(best_size) > need;
  assign need16   = need[fla_pkg::SIZE_W-1:0];
  assign g_hit    = gvalid[gi[fla_pkg::GIDX_W-1:0]] && (g_rd.addr == look_addr);

  // shared order compare for the sorted insert
  localparam int CMP_W = (fla_pkg::ADDR_BITS > fla_pkg::SIZE_W) ?
                         fla_pkg::ADDR_BITS : fla_pkg::SIZE_W;
  logic [CMP_W-1:0]                 cmp_a;
  logic [CMP_W-1:0]                 cmp_b;
  logic                             goes_before;

  always_comb begin
    case (return_order)
      fla_pkg::ORDER_ADDR: begin
        cmp_a = CMP_W'(key.addr);
        cmp_b = CMP_W'(f_rd.addr);
      end
      fla_pkg::ORDER_SIZE_UP: begin
        cmp_a = CMP_W'(key.size);
        cmp_b = CMP_W'(f_rd.size);
      end
      default: begin
        cmp_a = CMP_W'(f_rd.size);
        cmp_b = CMP_W'(key.size);
      end
    endcase
  end
  assign goes_before = cmp_a < cmp_b;

  // coalesce test
  logic                             abut;
  assign abut = f_rd.addr == (cur.addr + fla_pkg::ADDR_BITS'(cur.size));

  logic [fla_pkg::FCNT_W-1:0]       jp1;
  logic [fla_pkg::FCNT_W-1:0]       jm1;
  fla_pkg::chunk_t                  rel_chunk;
  assign jp1       = j + 1'b1;
  assign jm1       = j - 1'b1;
  assign rel_chunk = '{addr: look_addr, size: g_size};

  // memory port control
  always_comb begin
    f_we = 1'b0;
    f_wa = '0;
    f_wd = key;
    f_ra = '0;
    g_we = 1'b0;
    g_wa = grant_slot;
    g_wd = '{addr: best_addr, size: need16};
    g_ra = gi[fla_pkg::GIDX_W-1:0];
    if (rst) begin
      f_we = 1'b1;
      f_wd = '{addr: fla_pkg::RST_HEAP_BASE, size: fla_pkg::RST_HEAP_LENGTH};
    end else if (restart) begin
      f_we = 1'b1;
      f_wd = '{addr: new_base, size: new_len};
    end else begin
      unique case (state)
        S_FRD:   f_ra = fi[fla_pkg::FIDX_W-1:0];
        S_GEND: begin
          if (op_r == fla_pkg::OP_ALLOC) begin
            if (slot_ok && split) begin
              f_we = 1'b1;
              f_wa = best_idx;
              f_wd = '{addr: best_addr + fla_pkg::ADDR_BITS'(need16),
                       size: best_size - need16};
            end
          end else if (match_found && count < fla_pkg::FCNT_W'(fla_pkg::FREE_SLOTS) &&
                       return_order != fla_pkg::ORDER_FRONT) begin
            f_we = 1'b1;
            f_wa = count[fla_pkg::FIDX_W-1:0];
            f_wd = rel_chunk;
          end
        end
        S_RM_RD: f_ra = jp1[fla_pkg::FIDX_W-1:0];
        S_RM_WR: begin
          f_we = 1'b1;
          f_wa = j[fla_pkg::FIDX_W-1:0];
          f_wd = f_rd;
        end
        S_ALLOC_FIN: g_we = 1'b1;
        S_SH_RD, S_SORT_P: begin
          if (j != '0) begin
            f_ra = jm1[fla_pkg::FIDX_W-1:0];
          end else begin
            f_we = 1'b1;
          end
        end
        S_SH_WR: begin
          f_we = 1'b1;
          f_wa = j[fla_pkg::FIDX_W-1:0];
          f_wd = f_rd;
        end
        S_SORT_K: f_ra = ii[fla_pkg::FIDX_W-1:0];
        S_SORT_PC: begin
          f_we = 1'b1;
          f_wa = j[fla_pkg::FIDX_W-1:0];
          f_wd = goes_before ? f_rd : key;
        end
        S_MRG_RD: begin
          if (ii < count) begin
            f_ra = ii[fla_pkg::FIDX_W-1:0];
          end else begin
            f_we = 1'b1;
            f_wa = n[fla_pkg::FIDX_W-1:0];
            f_wd = cur;
          end
        end
        S_MRG_CMP: begin
          if (!abut) begin
            f_we = 1'b1;
            f_wa = n[fla_pkg::FIDX_W-1:0];
            f_wd = cur;
          end
        end
        default: ;
      endcase
    end
  end

  // handshake outputs
  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.grant_addr = out_addr;
  assign rsp.searched   = out_searched;

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      count           <= fla_pkg::FCNT_W'(1);
      gvalid          <= '0;
      fit_policy      <= fla_pkg::RST_FIT_POLICY;
      return_order    <= fla_pkg::RST_RETURN_ORDER;
      coalesce_enable <= 1'b0;
      alignment       <= '0;
      header_bytes    <= '0;
      heap_base       <= fla_pkg::RST_HEAP_BASE;
      heap_length     <= fla_pkg::RST_HEAP_LENGTH;
    end else begin
      // register writes
      if (cfg_write) begin
        unique case (cfg_index)
          fla_pkg::REG_FIT_POLICY:   fit_policy      <= cfg_data[1:0];
          fla_pkg::REG_RETURN_ORDER: return_order    <= cfg_data[2:0];
          fla_pkg::REG_COALESCE:     coalesce_enable <= cfg_data[0];
          fla_pkg::REG_ALIGNMENT:    alignment       <= cfg_data[fla_pkg::ALIGN_W-1:0];
          fla_pkg::REG_HEADER:       header_bytes    <= cfg_data[fla_pkg::HDR_W-1:0];
          fla_pkg::REG_HEAP_BASE:    heap_base       <= new_base;
          fla_pkg::REG_HEAP_LENGTH:  heap_length     <= new_len;
          default: ;
        endcase
      end
      if (restart) begin
        count  <= (new_len != '0) ? fla_pkg::FCNT_W'(1) : '0;
        gvalid <= '0;
      end

      // output register drains, unless a new result takes its place
      if (out_valid && rsp.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r         <= req.op;
            req_size     <= req.request_size;
            req_sh       <= req.request_size;
            look_addr    <= req.release_addr;
            rem          <= '0;
            bit_ctr      <= BITCNT_W'(fla_pkg::REQ_W);
            res_status   <= fla_pkg::STATUS_OK;
            res_addr     <= '0;
            res_searched <= '0;
            gi           <= '0;
            match_found  <= 1'b0;
            free_found   <= 1'b0;
            if (req.op == fla_pkg::OP_ALLOC) begin
              state <= (alignment != '0) ? S_ALIGN : S_NEED;
            end else begin
              state <= S_GRD;
            end
          end
        end
        S_ALIGN: begin
          rem     <= (div_try >= {1'b0, alignment}) ? div_diff[fla_pkg::ALIGN_W-1:0] :
                                                     div_try[fla_pkg::ALIGN_W-1:0];
          req_sh  <= req_sh << 1;
          bit_ctr <= bit_ctr - 1'b1;
          if (bit_ctr == BITCNT_W'(1)) begin
            state <= S_NEED;
          end
        end
        S_NEED: begin
          need  <= need_calc;
          fi    <= '0;
          cnt   <= '0;
          found <= 1'b0;
          if (need_calc == '0) begin
            res_status <= fla_pkg::STATUS_NO_FIT;
            state      <= S_RESP;
          end else begin
            state <= S_FRD;
          end
        end
        // free list search
        S_FRD: state <= (fi < count) ? S_FCMP : S_FEND;
        S_FCMP: begin
          cnt <= cnt + 1'b1;
          if (fit_hit) begin
            found     <= 1'b1;
            best_idx  <= fi[fla_pkg::FIDX_W-1:0];
            best_size <= f_rd.size;
            best_addr <= f_rd.addr;
          end
          if (fit_hit && fit_first) begin
            state <= S_FEND;
          end else begin
            fi    <= fi + 1'b1;
            state <= S_FRD;
          end
        end
        S_FEND: begin
          res_searched <= fla_pkg::SEARCH_W'(cnt);
          look_addr    <= best_addr;
          if (!found) begin
            res_status <= fla_pkg::STATUS_NO_FIT;
            state      <= S_RESP;
          end else begin
            state <= S_GRD;
          end
        end
        // grant table scan
        S_GRD: state <= (gi < fla_pkg::GCNT_W'(fla_pkg::GRANT_SLOTS)) ? S_GCMP : S_GEND;
        S_GCMP: begin
          if (g_hit) begin
            match_found <= 1'b1;
            match_slot  <= gi[fla_pkg::GIDX_W-1:0];
            g_size      <= g_rd.size;
            state       <= S_GEND;
          end else begin
            if (!gvalid[gi[fla_pkg::GIDX_W-1:0]] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= gi[fla_pkg::GIDX_W-1:0];
            end
            gi    <= gi + 1'b1;
            state <= S_GRD;
          end
        end
        S_GEND: begin
          if (op_r == fla_pkg::OP_ALLOC) begin
            grant_slot <= slot_sel;
            if (!slot_ok) begin
              res_status <= fla_pkg::STATUS_FULL;
              state      <= S_RESP;
            end else if (split) begin
              state <= S_ALLOC_FIN;
            end else begin
              j     <= fla_pkg::FCNT_W'(best_idx);
              state <= S_RM_RD;
            end
          end else begin
            grant_slot <= match_slot;
            key        <= rel_chunk;
            if (!match_found) begin
              res_status <= fla_pkg::STATUS_NOT_ALLOC;
              state      <= S_RESP;
            end else if (count >= fla_pkg::FCNT_W'(fla_pkg::FREE_SLOTS)) begin
              res_status <= fla_pkg::STATUS_FULL;
              state      <= S_RESP;
            end else if (return_order == fla_pkg::ORDER_FRONT) begin
              j     <= count;
              state <= S_SH_RD;
            end else begin
              count <= count + 1'b1;
              ii    <= fla_pkg::FCNT_W'(1);
              if (return_order == fla_pkg::ORDER_ADDR ||
                  return_order == fla_pkg::ORDER_SIZE_UP ||
                  return_order == fla_pkg::ORDER_SIZE_DN) begin
                state <= S_SORT_K;
              end else begin
                state <= S_MRG_START;
              end
            end
          end
        end
        // remove an exactly fitting chunk
        S_RM_RD: begin
          if (jp1 < count) begin
            state <= S_RM_WR;
          end else begin
            count <= count - 1'b1;
            state <= S_ALLOC_FIN;
          end
        end
        S_RM_WR: begin
          j     <= jp1;
          state <= S_RM_RD;
        end
        S_ALLOC_FIN: begin
          gvalid[grant_slot] <= 1'b1;
          res_status         <= fla_pkg::STATUS_OK;
          res_addr           <= best_addr;
          state              <= S_RESP;
        end
        // front insert
        S_SH_RD: begin
          if (j != '0) begin
            state <= S_SH_WR;
          end else begin
            count <= count + 1'b1;
            state <= S_MRG_START;
          end
        end
        S_SH_WR: begin
          j     <= jm1;
          state <= S_SH_RD;
        end
        // stable insertion sort
        S_SORT_K: state <= (ii < count) ? S_SORT_KW : S_MRG_START;
        S_SORT_KW: begin
          key   <= f_rd;
          j     <= ii;
          state <= S_SORT_P;
        end
        S_SORT_P: begin
          if (j != '0) begin
            state <= S_SORT_PC;
          end else begin
            ii    <= ii + 1'b1;
            state <= S_SORT_K;
          end
        end
        S_SORT_PC: begin
          if (goes_before) begin
            j     <= jm1;
            state <= S_SORT_P;
          end else begin
            ii    <= ii + 1'b1;
            state <= S_SORT_K;
          end
        end
        // coalesce pass
        S_MRG_START: state <= coalesce_enable ? S_MRG_FIRST : S_FREE_FIN;
        S_MRG_FIRST: begin
          cur   <= f_rd;
          n     <= '0;
          ii    <= fla_pkg::FCNT_W'(1);
          state <= S_MRG_RD;
        end
        S_MRG_RD: begin
          if (ii < count) begin
            state <= S_MRG_CMP;
          end else begin
            count <= n + 1'b1;
            state <= S_FREE_FIN;
          end
        end
        S_MRG_CMP: begin
          if (abut) begin
            cur.size <= cur.size + f_rd.size;
          end else begin
            n   <= n + 1'b1;
            cur <= f_rd;
          end
          ii    <= ii + 1'b1;
          state <= S_MRG_RD;
        end
        S_FREE_FIN: begin
          gvalid[grant_slot] <= 1'b0;
          res_status         <= fla_pkg::STATUS_OK;
          state              <= S_RESP;
        end
        // hand the result to the output register
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_status   <= res_status;
            out_addr     <= res_addr;
            out_searched <= res_searched;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/fla_checker.sv
// port-level checks of the free list heap allocator, bound to the top level
// depends on fla_pkg and assert_macros.svh
`include "assert_macros.svh"

module fla_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fla_pkg::STATUS_W-1:0]      status,
  input logic [fla_pkg::ADDR_BITS-1:0]     grant_addr,
  input logic [fla_pkg::SEARCH_W-1:0]      searched
);

  // a failed request never carries an address
  `FLA_ASSERT(a_addr_only_on_ok, clk, rst, out_valid && status != fla_pkg::STATUS_OK, grant_addr == '0)

  // a free of an unknown address runs no search
  `FLA_ASSERT(a_unknown_no_search, clk, rst, out_valid && status == fla_pkg::STATUS_NOT_ALLOC, searched == '0)

  // the search never visits more entries than the list holds
  `FLA_ASSERT(a_search_bound, clk, rst, out_valid, searched <= fla_pkg::SEARCH_W'(fla_pkg::FREE_SLOTS))

  // a taken request keeps the block busy on the next cycle
  `FLA_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `FLA_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(grant_addr) && $stable(searched))

endmodule

bind free_list_heap_allocator fla_checker u_fla_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .status     (rsp.status),
  .grant_addr (rsp.grant_addr),
  .searched   (rsp.searched)
);

FILE: dv/testbench.sv
// self-checking testbench of the free list heap allocator
// depends on fla_pkg, fla_req_if, fla_rsp_if and free_list_heap_allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 40_000_000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 129;

  typedef struct {
    fla_pkg::status_t status;
    logic [15:0]      grant_addr;
    logic [6:0]       searched;
  } result_t;

  typedef struct {
    logic             op;
    logic [15:0]      size;
    logic [15:0]      addr;
    bit               fixed;
    fla_pkg::status_t status;
    logic [15:0]      grant_addr;
    logic [6:0]       searched;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [fla_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fla_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fla_req_if req ();
  fla_rsp_if rsp ();

  free_list_heap_allocator dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow configuration and allocator state
  int unsigned fit_sel, order_sel, merge_on, align_units, hdr_units, base_addr, heap_len;
  int unsigned free_addr[fla_pkg::FREE_SLOTS];
  int unsigned free_size[fla_pkg::FREE_SLOTS];
  int unsigned free_cnt;
  bit          grant_live[fla_pkg::GRANT_SLOTS];
  int unsigned grant_addr[fla_pkg::GRANT_SLOTS];
  int unsigned grant_size[fla_pkg::GRANT_SLOTS];

  result_t pending_results[$];
  int errors = 0;
  int unsigned cycles = 0;
  int idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // add one expected result at the tail of the queue
  task automatic expect_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  function automatic void restart_heap();
    free_cnt = 0;
    for (int i = 0; i < fla_pkg::GRANT_SLOTS; i++) grant_live[i] = 1'b0;
    if (heap_len != 0) begin
      free_addr[0] = base_addr & 16'hFFFF;
      free_size[0] = heap_len;
      free_cnt = 1;
    end
  endfunction

  function automatic bit sorts_ahead(int unsigned aa, int unsigned as_, int unsigned ba,
                                     int unsigned bs);
    if (order_sel == fla_pkg::ORDER_ADDR) return aa < ba;
    if (order_sel == fla_pkg::ORDER_SIZE_UP) return as_ < bs;
    return as_ > bs;
  endfunction

  // allocation: round, add header, search, split or remove, record grant
  function automatic result_t alloc_chunk(int unsigned want);
    result_t r;
    int unsigned need, visited, pick, best_size, slot, a;
    bit found;
    r = '{fla_pkg::STATUS_OK, 16'd0, 7'd0};
    need = want;
    if (align_units != 0 && need % align_units != 0)
      need += align_units - need % align_units;
    need += hdr_units;
    if (need == 0) begin
      r.status = fla_pkg::STATUS_NO_FIT;
      return r;
    end
    visited = 0; found = 0; pick = 0; best_size = 0;
    for (int i = 0; i < free_cnt; i++) begin
      visited++;
      if (free_size[i] >= need && (!found ||
          (fit_sel == fla_pkg::FIT_BEST && free_size[i] < best_size) ||
          (fit_sel == fla_pkg::FIT_WORST && free_size[i] > best_size) ||
          fit_sel >= fla_pkg::FIT_FIRST)) begin
        found = 1; pick = i; best_size = free_size[i];
        if (fit_sel >= fla_pkg::FIT_FIRST) break;
      end
    end
    r.searched = visited > 127 ? 7'd127 : visited[6:0];
    if (!found) begin
      r.status = fla_pkg::STATUS_NO_FIT;
      return r;
    end
    a = free_addr[pick];
    slot = fla_pkg::GRANT_SLOTS;
    for (int i = 0; i < fla_pkg::GRANT_SLOTS; i++)
      if (grant_live[i] && grant_addr[i] == a) begin slot = i; break; end
    if (slot == fla_pkg::GRANT_SLOTS)
      for (int i = 0; i < fla_pkg::GRANT_SLOTS; i++)
        if (!grant_live[i]) begin slot = i; break; end
    if (slot == fla_pkg::GRANT_SLOTS) begin
      r.status = fla_pkg::STATUS_FULL;
      return r;
    end
    if (best_size > need) begin
      free_addr[pick] = (a + need) & 16'hFFFF;
      free_size[pick] = best_size - need;
    end else begin
      for (int i = pick; i + 1 < free_cnt; i++) begin
        free_addr[i] = free_addr[i+1];
        free_size[i] = free_size[i+1];
      end
      free_cnt--;
    end
    grant_live[slot] = 1'b1;
    grant_addr[slot] = a;
    grant_size[slot] = need;
    r.grant_addr = a[15:0];
    return r;
  endfunction

  // release: look up grant, insert by return order, merge abutting neighbours
  function automatic result_t release_chunk(int unsigned where);
    result_t r;
    int unsigned slot, ka, ks, j, n, ca, cs;
    r = '{fla_pkg::STATUS_OK, 16'd0, 7'd0};
    slot = fla_pkg::GRANT_SLOTS;
    for (int i = 0; i < fla_pkg::GRANT_SLOTS; i++)
      if (grant_live[i] && grant_addr[i] == where) begin slot = i; break; end
    if (slot == fla_pkg::GRANT_SLOTS) begin
      r.status = fla_pkg::STATUS_NOT_ALLOC;
      return r;
    end
    if (free_cnt >= fla_pkg::FREE_SLOTS) begin
      r.status = fla_pkg::STATUS_FULL;
      return r;
    end
    if (order_sel == fla_pkg::ORDER_FRONT) begin
      for (int i = free_cnt; i > 0; i--) begin
        free_addr[i] = free_addr[i-1];
        free_size[i] = free_size[i-1];
      end
      free_addr[0] = where;
      free_size[0] = grant_size[slot];
      free_cnt++;
    end else begin
      free_addr[free_cnt] = where;
      free_size[free_cnt] = grant_size[slot];
      free_cnt++;
      if (order_sel >= fla_pkg::ORDER_ADDR && order_sel <= fla_pkg::ORDER_SIZE_DN)
        for (int i = 1; i < free_cnt; i++) begin
          ka = free_addr[i]; ks = free_size[i]; j = i;
          while (j > 0 && sorts_ahead(ka, ks, free_addr[j-1], free_size[j-1])) begin
            free_addr[j] = free_addr[j-1];
            free_size[j] = free_size[j-1];
            j--;
          end
          free_addr[j] = ka; free_size[j] = ks;
        end
    end
    if (merge_on != 0) begin
      n = 0; ca = free_addr[0]; cs = free_size[0];
      for (int i = 1; i < free_cnt; i++) begin
        if (free_addr[i] == ((ca + cs) & 16'hFFFF)) cs += free_size[i];
        else begin
          free_addr[n] = ca; free_size[n] = cs; n++;
          ca = free_addr[i]; cs = free_size[i];
        end
      end
      free_addr[n] = ca; free_size[n] = cs; n++;
      free_cnt = n;
    end
    grant_live[slot] = 1'b0;
    return r;
  endfunction

  function automatic result_t predict_request(logic op, logic [15:0] size, logic [15:0] addr);
    if (op == fla_pkg::OP_ALLOC) return alloc_chunk(32'(size));
    return release_chunk(32'(addr));
  endfunction

  task automatic write_reg(input logic [fla_pkg::CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fla_pkg::REG_FIT_POLICY:   fit_sel = val & 3;
      fla_pkg::REG_RETURN_ORDER: order_sel = val & 7;
      fla_pkg::REG_COALESCE:     merge_on = val & 1;
      fla_pkg::REG_ALIGNMENT:    align_units = val & 16'h1FFF;
      fla_pkg::REG_HEADER:       hdr_units = val & 8'hFF;
      fla_pkg::REG_HEAP_BASE:    begin base_addr = val & 16'hFFFF; restart_heap(); end
      fla_pkg::REG_HEAP_LENGTH:  begin heap_len = val & 16'hFFFF; restart_heap(); end
      default: ;
    endcase
  endtask

  // one request through the handshake; returns the predicted result
  task automatic send_request(input logic op, input logic [15:0] size, input logic [15:0] addr,
                              output result_t r);
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(99) < (idle_mode == 1 ? 75 : 29)) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.request_size <= size;
    req.release_addr <= addr;
    do @(posedge clk); while (!req.ready);
    r = predict_request(op, size, addr);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // response checking and receiver stalls
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) report("result with no request outstanding");
      else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          report($sformatf("status %0d, wanted %0d", rsp.status, want.status));
        if (rsp.grant_addr !== want.grant_addr)
          report($sformatf("grant_addr %0d, wanted %0d", rsp.grant_addr, want.grant_addr));
        if (rsp.searched !== want.searched)
          report($sformatf("searched %0d, wanted %0d", rsp.searched, want.searched));
      end
    end
    if (idle_mode == 2) rsp.ready <= ($urandom_range(99) >= 75);
    else if (idle_mode == 3) rsp.ready <= ($urandom_range(99) >= 29);
    else rsp.ready <= 1'b1;
  end

  function automatic logic [15:0] pick_release_addr();
    int unsigned live[$];
    for (int i = 0; i < fla_pkg::GRANT_SLOTS; i++)
      if (grant_live[i]) live.insert(live.size(), grant_addr[i]);
    if (live.size() == 0 || $urandom_range(99) < 8) return 16'($urandom_range(16'hFFFF));
    return 16'(live[$urandom_range(live.size() - 1)]);
  endfunction

  initial begin
    row_t rows[16];
    result_t r;
    int unsigned span;
    req.valid = 1'b0;
    req.op = fla_pkg::OP_ALLOC;
    req.request_size = '0;
    req.release_addr = '0;
    rsp.ready = 1'b0;
    fit_sel = 32'(fla_pkg::RST_FIT_POLICY);
    order_sel = 32'(fla_pkg::RST_RETURN_ORDER);
    merge_on = 0;
    align_units = 0; hdr_units = 0;
    base_addr = 32'(fla_pkg::RST_HEAP_BASE);
    heap_len = 32'(fla_pkg::RST_HEAP_LENGTH);
    restart_heap();

    rows = '{
      '{fla_pkg::OP_ALLOC, 16'd0,    16'd0,    1, fla_pkg::STATUS_NO_FIT,    16'd0,    7'd0},
      '{fla_pkg::OP_ALLOC, 16'd100,  16'd0,    1, fla_pkg::STATUS_OK,        16'd1000, 7'd1},
      '{fla_pkg::OP_ALLOC, 16'd1,    16'd0,    1, fla_pkg::STATUS_NO_FIT,    16'd0,    7'd0},
      '{fla_pkg::OP_FREE,  16'd0,    16'd1000, 1, fla_pkg::STATUS_OK,        16'd0,    7'd0},
      '{fla_pkg::OP_FREE,  16'd0,    16'd1000, 1, fla_pkg::STATUS_NOT_ALLOC, 16'd0,    7'd0},
      '{fla_pkg::OP_ALLOC, 16'hFFFF, 16'd0,    1, fla_pkg::STATUS_NO_FIT,    16'd0,    7'd1},
      '{fla_pkg::OP_ALLOC, 16'd10,   16'd0,    1, fla_pkg::STATUS_OK,        16'd1000, 7'd1},
      '{fla_pkg::OP_ALLOC, 16'd20,   16'd0,    1, fla_pkg::STATUS_OK,        16'd1010, 7'd1},
      '{fla_pkg::OP_FREE,  16'd0,    16'hFFFF, 1, fla_pkg::STATUS_NOT_ALLOC, 16'd0,    7'd0},
      '{fla_pkg::OP_FREE,  16'hFFFF, 16'd0,    1, fla_pkg::STATUS_NOT_ALLOC, 16'd0,    7'd0},
      '{fla_pkg::OP_FREE,  16'd0,    16'd1000, 0, fla_pkg::STATUS_OK,        16'd0,    7'd0},
      '{fla_pkg::OP_ALLOC, 16'd5,    16'd0,    0, fla_pkg::STATUS_OK,        16'd0,    7'd0},
      '{fla_pkg::OP_ALLOC, 16'd70,   16'd0,    0, fla_pkg::STATUS_OK,        16'd0,    7'd0},
      '{fla_pkg::OP_FREE,  16'd0,    16'd1010, 0, fla_pkg::STATUS_OK,        16'd0,    7'd0},
      '{fla_pkg::OP_FREE,  16'd0,    16'd1005, 0, fla_pkg::STATUS_OK,        16'd0,    7'd0},
      '{fla_pkg::OP_ALLOC, 16'd1,    16'd0,    0, fla_pkg::STATUS_OK,        16'd0,    7'd0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows against the reset configuration
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].size, rows[i].addr, r);
      if (rows[i].fixed) begin
        if (r.status != rows[i].status || r.grant_addr != rows[i].grant_addr ||
            r.searched != rows[i].searched)
          report($sformatf("table row %0d disagrees with prediction", i));
        r.status = rows[i].status;
        r.grant_addr = rows[i].grant_addr;
        r.searched = rows[i].searched;
      end
      expect_result(r);
    end
    drain();

    // fill the grant table, then the free list, with a 65 unit heap
    write_reg(fla_pkg::REG_RETURN_ORDER, 32'(fla_pkg::ORDER_BACK));
    write_reg(fla_pkg::REG_HEAP_BASE, 32'hFFF0);
    write_reg(fla_pkg::REG_HEAP_LENGTH, 65);
    for (int i = 0; i < 65; i++) begin
      send_request(fla_pkg::OP_ALLOC, 16'd1, 16'd0, r);
      expect_result(r);
    end
    for (int i = 0; i < 64; i++) begin
      send_request(fla_pkg::OP_FREE, 16'd0, 16'((32'hFFF0 + i) & 32'hFFFF), r);
      expect_result(r);
    end
    drain();

    // random phases, each with its own configuration and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_mode = ph % 4;
      write_reg(fla_pkg::REG_FIT_POLICY, $urandom_range(3));
      write_reg(fla_pkg::REG_RETURN_ORDER, (ph == 1) ? 7 : $urandom_range(7));
      write_reg(fla_pkg::REG_COALESCE, (ph < 2) ? ph : $urandom_range(1));
      case (ph % 5)
        0: write_reg(fla_pkg::REG_ALIGNMENT, 0);
        1: write_reg(fla_pkg::REG_ALIGNMENT, 4096);
        default: write_reg(fla_pkg::REG_ALIGNMENT, $urandom_range(16));
      endcase
      write_reg(fla_pkg::REG_HEADER, (ph == 2) ? 255 : $urandom_range(255) * $urandom_range(1));
      write_reg(fla_pkg::REG_HEAP_BASE, (ph == 3) ? 32'hFFFF : $urandom_range(16'hFFFF));
      case (ph)
        4:  write_reg(fla_pkg::REG_HEAP_LENGTH, 0);
        5:  write_reg(fla_pkg::REG_HEAP_LENGTH, 1);
        6, 11: write_reg(fla_pkg::REG_HEAP_LENGTH, 32'hFFFF);
        default: write_reg(fla_pkg::REG_HEAP_LENGTH, $urandom_range(4000, 50));
      endcase
      span = heap_len / 8 + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 60) begin
          req.valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 55) begin
          if ($urandom_range(99) < 10)
            send_request(fla_pkg::OP_ALLOC, 16'($urandom_range(16'hFFFF)),
                         16'($urandom_range(16'hFFFF)), r);
          else
            send_request(fla_pkg::OP_ALLOC, 16'($urandom_range(span)),
                         16'($urandom_range(16'hFFFF)), r);
        end else
          send_request(fla_pkg::OP_FREE, 16'($urandom_range(16'hFFFF)), pick_release_addr(), r);
        expect_result(r);
      end
      drain();
    end

    idle_mode = 0;
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
